/* rtl/core/mwm_pkg.sv */
// ----------------------------------------------------------------------------
// mwm_pkg: shared types and constants
// Memory control groups and a fixed field width for the window-minimum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwm_pkg;

    // Width of the window_size result field.
    localparam int WIN_BITS = 7;

    // Control group for the stack memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } stk_ctl_t;

    // Control group for the per-size best store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } best_ctl_t;

endpackage

/* rtl/core/mwm_stack_mem.sv */
// ----------------------------------------------------------------------------
// mwm_stack_mem: monotonic stack storage
// Holds stack entries (element index and value), one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwm_stack_mem
    import mwm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 26,
    parameter int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  stk_ctl_t             ctl,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/mwm_best_mem.sv */
// ----------------------------------------------------------------------------
// mwm_best_mem: best minimum per window size
// Synchronous store with one valid bit per entry; an entry not written since
// the last clear reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwm_best_mem
    import mwm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 20,
    parameter int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  best_ctl_t            ctl,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* rtl/core/max_of_window_minimums.sv */
// Sequence: a request that pops nothing is accepted, then compared and pushed. Each
// pop it causes reads the best store, writes it back, then compares again.
// A last request then drains the stack, runs a suffix-maximum pass and emits one result
// per window size for a set of n values. A new value is taken only once the previous one
// is fully handled, and result stalls hold up the emission of results.
// Reset clears all control state and the best store's valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// max_of_window_minimums: maximum of the window minimums for every window size
// Stack-based span search over a set of values, with a per-size best store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_of_window_minimums
    import mwm_pkg::*;
#(
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input request channel: one value per request.
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,

    // Result channel: one request per window size.
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [WIN_BITS-1:0]   window_size,
    output logic [VALUE_BITS-1:0] best_minimum,
    output logic                  final_res,
    output logic                  overflow
);

    // IW indexes the stores; CW holds a count from 0 to MAX_LEN.
    localparam int IW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int SEW = IW + VALUE_BITS;

    // The sequencer walks these states. A value is compared against the stack
    // top, larger entries are popped one by one (each pop reads the best entry
    // for its span and writes it back in the next cycle), then the value is
    // pushed. After the last value the stack is drained, a suffix maximum is
    // formed from the largest size down, and the results are read out.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_POP,
        ST_POP_WR,
        ST_SUF_RD,
        ST_SUF_WR,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic                  last_reg, last_next;
    logic                  drain_reg, drain_next;
    logic                  dropped_reg, dropped_next;
    logic [CW-1:0]         depth_reg, depth_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         top_idx_reg, top_idx_next;
    logic [VALUE_BITS-1:0] top_val_reg, top_val_next;
    logic [IW-1:0]         below_idx_reg, below_idx_next;
    logic [VALUE_BITS-1:0] below_val_reg, below_val_next;
    logic [VALUE_BITS-1:0] pop_val_reg, pop_val_next;
    logic [IW-1:0]         best_addr_reg, best_addr_next;
    logic [VALUE_BITS-1:0] run_reg, run_next;
    logic [CW-1:0]         addr_reg, addr_next;
    logic                  res_valid_reg, res_valid_next;
    logic [WIN_BITS-1:0]   window_size_reg, window_size_next;
    logic [VALUE_BITS-1:0] best_minimum_reg, best_minimum_next;
    logic                  final_res_reg, final_res_next;
    logic                  overflow_reg, overflow_next;

    stk_ctl_t              stk_ctl;
    logic [IW-1:0]         stk_wr_addr;
    logic [SEW-1:0]        stk_wr_data;
    logic [IW-1:0]         stk_rd_addr;
    logic [SEW-1:0]        stk_rd_data;

    best_ctl_t             best_ctl;
    logic [IW-1:0]         best_wr_addr;
    logic [VALUE_BITS-1:0] best_wr_data;
    logic [IW-1:0]         best_rd_addr;
    logic [VALUE_BITS-1:0] best_rd_data;

    logic [CW-1:0]         span;
    logic [VALUE_BITS-1:0] run_max;
    logic                  out_free;
    logic                  is_final;

    mwm_stack_mem #(
        .DEPTH (MAX_LEN),
        .WIDTH (SEW)
    ) u_stack (
        .clk     (clk),
        .ctl     (stk_ctl),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    mwm_best_mem #(
        .DEPTH (MAX_LEN),
        .WIDTH (VALUE_BITS)
    ) u_best (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (best_ctl),
        .wr_addr (best_wr_addr),
        .wr_data (best_wr_data),
        .rd_addr (best_rd_addr),
        .rd_data (best_rd_data)
    );

    // The popped top spans from just right of the entry below it up to the
    // current edge; with nothing below, it spans from the start of the set.
    assign span = (depth_reg == CW'(1)) ? count_reg
                                        : CW'(count_reg - CW'(below_idx_reg) - CW'(1));

    assign run_max  = (best_rd_data > run_reg) ? best_rd_data : run_reg;
    assign out_free = !res_valid_reg || !res_stall;
    assign is_final = (CW'(addr_reg + CW'(1)) == count_reg);

    always_comb
    begin
        state_next        = state_reg;
        v_next            = v_reg;
        last_next         = last_reg;
        drain_next        = drain_reg;
        dropped_next      = dropped_reg;
        depth_next        = depth_reg;
        count_next        = count_reg;
        top_idx_next      = top_idx_reg;
        top_val_next      = top_val_reg;
        below_idx_next    = below_idx_reg;
        below_val_next    = below_val_reg;
        pop_val_next      = pop_val_reg;
        best_addr_next    = best_addr_reg;
        run_next          = run_reg;
        addr_next         = addr_reg;
        res_valid_next    = res_valid_reg && res_stall;
        window_size_next  = window_size_reg;
        best_minimum_next = best_minimum_reg;
        final_res_next    = final_res_reg;
        overflow_next     = overflow_reg;

        stk_ctl      = '0;
        stk_wr_addr  = IW'(depth_reg);
        stk_wr_data  = {IW'(count_reg), v_reg};
        stk_rd_addr  = IW'(depth_reg - CW'(3));
        best_ctl     = '0;
        best_wr_addr = best_addr_reg;
        best_wr_data = pop_val_reg;
        best_rd_addr = IW'(span - CW'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    v_next    = value;
                    last_next = last;
                    if (count_reg < CW'(MAX_LEN))
                    begin
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        // The store is full: the value is dropped, but a last
                        // request still closes the set.
                        dropped_next = 1'b1;
                        if (last)
                        begin
                            drain_next = 1'b1;
                            state_next = ST_POP;
                        end
                    end
                end
            end

            ST_CMP:
            begin
                if (depth_reg != '0 && top_val_reg > v_reg)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    stk_ctl.wr_en  = 1'b1;
                    below_idx_next = top_idx_reg;
                    below_val_next = top_val_reg;
                    top_idx_next   = IW'(count_reg);
                    top_val_next   = v_reg;
                    depth_next     = CW'(depth_reg + CW'(1));
                    count_next     = CW'(count_reg + CW'(1));
                    if (last_reg)
                    begin
                        drain_next = 1'b1;
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_POP:
            begin
                best_ctl.rd_en = 1'b1;
                stk_ctl.rd_en  = (depth_reg >= CW'(3));
                best_addr_next = IW'(span - CW'(1));
                pop_val_next   = top_val_reg;
                top_idx_next   = below_idx_reg;
                top_val_next   = below_val_reg;
                depth_next     = CW'(depth_reg - CW'(1));
                state_next     = ST_POP_WR;
            end

            ST_POP_WR:
            begin
                below_idx_next = stk_rd_data[SEW-1 -: IW];
                below_val_next = stk_rd_data[VALUE_BITS-1:0];
                best_ctl.wr_en = (best_rd_data < pop_val_reg);
                if (!drain_reg)
                begin
                    state_next = ST_CMP;
                end
                else if (depth_reg != '0)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    addr_next  = CW'(count_reg - CW'(1));
                    run_next   = '0;
                    state_next = ST_SUF_RD;
                end
            end

            ST_SUF_RD:
            begin
                best_ctl.rd_en = 1'b1;
                best_rd_addr   = IW'(addr_reg);
                state_next     = ST_SUF_WR;
            end

            ST_SUF_WR:
            begin
                best_ctl.wr_en = 1'b1;
                best_wr_addr   = IW'(addr_reg);
                best_wr_data   = run_max;
                run_next       = run_max;
                if (addr_reg == '0)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    addr_next  = CW'(addr_reg - CW'(1));
                    state_next = ST_SUF_RD;
                end
            end

            ST_EMIT_RD:
            begin
                best_ctl.rd_en = 1'b1;
                best_rd_addr   = IW'(addr_reg);
                state_next     = ST_EMIT_WR;
            end

            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    res_valid_next    = 1'b1;
                    window_size_next  = WIN_BITS'(addr_reg + CW'(1));
                    best_minimum_next = best_rd_data;
                    final_res_next    = is_final;
                    overflow_next     = dropped_reg;
                    if (is_final)
                    begin
                        // The set is closed: stack, value count, flags and valid bits return to their reset state.
                        best_ctl.clear = 1'b1;
                        depth_next     = '0;
                        count_next     = '0;
                        dropped_next   = 1'b0;
                        drain_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        addr_next  = CW'(addr_reg + CW'(1));
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            v_reg            <= '0;
            last_reg         <= 1'b0;
            drain_reg        <= 1'b0;
            dropped_reg      <= 1'b0;
            depth_reg        <= '0;
            count_reg        <= '0;
            top_idx_reg      <= '0;
            top_val_reg      <= '0;
            below_idx_reg    <= '0;
            below_val_reg    <= '0;
            pop_val_reg      <= '0;
            best_addr_reg    <= '0;
            run_reg          <= '0;
            addr_reg         <= '0;
            res_valid_reg    <= 1'b0;
            window_size_reg  <= '0;
            best_minimum_reg <= '0;
            final_res_reg    <= 1'b0;
            overflow_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            v_reg            <= v_next;
            last_reg         <= last_next;
            drain_reg        <= drain_next;
            dropped_reg      <= dropped_next;
            depth_reg        <= depth_next;
            count_reg        <= count_next;
            top_idx_reg      <= top_idx_next;
            top_val_reg      <= top_val_next;
            below_idx_reg    <= below_idx_next;
            below_val_reg    <= below_val_next;
            pop_val_reg      <= pop_val_next;
            best_addr_reg    <= best_addr_next;
            run_reg          <= run_next;
            addr_reg         <= addr_next;
            res_valid_reg    <= res_valid_next;
            window_size_reg  <= window_size_next;
            best_minimum_reg <= best_minimum_next;
            final_res_reg    <= final_res_next;
            overflow_reg     <= overflow_next;
        end
    end

    // New values are taken only while the sequencer is idle; results already
    // waiting in the output register do not hold up the input side.
    assign item_stall   = (state_reg != ST_IDLE);
    assign res_valid    = res_valid_reg;
    assign window_size  = window_size_reg;
    assign best_minimum = best_minimum_reg;
    assign final_res    = final_res_reg;
    assign overflow     = overflow_reg;

    // The stack never holds more entries than values stored in the set.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= count_reg && count_reg <= CW'(MAX_LEN))
    else $error("stack depth or value count out of range");

    // Before each compare the two top entries are in nondecreasing order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && depth_reg >= CW'(2)) |-> below_val_reg <= top_val_reg)
    else $error("stack order broken");

    // The final result of a set leaves the block idle with an empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_WR && out_free && is_final)
        |=> (state_reg == ST_IDLE && depth_reg == '0 && count_reg == '0 && final_res_reg))
    else $error("set did not close after its final result");

    // The suffix pass and result read-out only happen once the set is closing and the stack is drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUF_RD || state_reg == ST_SUF_WR || state_reg == ST_EMIT_RD)
        |-> (drain_reg && depth_reg == '0 && count_reg != '0))
    else $error("result pass entered outside a closing set");

endmodule
